// ----- design/pca_pkg.sv -----
// shared widths, register indexes and controller state codes for the pid block
package pca_pkg;

    // bit-serial multiplier: 32-bit multiplicand, 48-bit multiplier
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 48;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // restoring divider: 64-bit dividend, 32-bit divisor
    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 32;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_BIAS = 3'd3
    } cfg_reg_t;

    // one-hot sequencer states
    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_DMUL  = 12'b0000_0000_0010,
        ST_DDIV  = 12'b0000_0000_0100,
        ST_PMUL  = 12'b0000_0000_1000,
        ST_DKMUL = 12'b0000_0001_0000,
        ST_IMUL  = 12'b0000_0010_0000,
        ST_IDIV  = 12'b0000_0100_0000,
        ST_LDIV  = 12'b0000_1000_0000,
        ST_CAND  = 12'b0001_0000_0000,
        ST_KCMUL = 12'b0010_0000_0000,
        ST_IFMUL = 12'b0100_0000_0000,
        ST_OUT   = 12'b1000_0000_0000
    } pca_state_t;

endpackage

// ----- design/pca_in_if.sv -----
// input channel: setpoint, measurement and elapsed time
interface pca_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] target_value;
    logic signed [31:0] measured_value;
    logic        [15:0] elapsed_ms;

    modport source (output valid, output target_value, output measured_value,
                    output elapsed_ms, input ready);
    modport sink   (input valid, input target_value, input measured_value,
                    input elapsed_ms, output ready);
endinterface

// ----- design/pca_out_if.sv -----
// output channel: clamped drive and the three controller terms
interface pca_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] drive_value;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;

    modport source (output valid, output drive_value, output p_term, output i_term,
                    output d_term, input ready);
    modport sink   (input valid, input drive_value, input p_term, input i_term,
                    input d_term, output ready);
endinterface

// ----- design/pca_mul.sv -----
// bit-serial shift-add multiplier, one multiplier bit per cycle
module pca_mul
    import pca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [MUL_A_W-1:0]   a,
    input  logic [MUL_B_W-1:0]   b,
    output logic [PROD_W-1:0]    prod,
    output logic                 done
);

    localparam logic [MUL_CNT_W-1:0] LAST = MUL_CNT_W'(MUL_B_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [PROD_W-1:0]    acc_next;
    logic [MUL_A_W-1:0]   mcand_reg;
    logic [MUL_A_W:0]     sum;

    // add multiplicand into the upper half when the low bit is set, then shift the whole word right
    always_comb
    begin
        sum      = {1'b0, acc_reg[PROD_W-1:MUL_B_W]}
                 + {1'b0, (acc_reg[0] ? mcand_reg : {MUL_A_W{1'b0}})};
        acc_next = {sum, acc_reg[MUL_B_W-1:1]};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            acc_reg <= acc_next;
        end
        else if (start)
        begin
            acc_reg   <= {{MUL_A_W{1'b0}}, b};
            mcand_reg <= a;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

// ----- design/pca_div.sv -----
// restoring divider, one quotient bit per cycle
module pca_div
    import pca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_N_W-1:0]   dividend,
    input  logic [DIV_D_W-1:0]   divisor,
    output logic [DIV_N_W-1:0]   quotient,
    output logic                 done
);

    localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_N_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_D_W-1:0]   rem_next;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_N_W-1:0]   quo_next;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    // bring down the next dividend bit and try a subtract
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_N_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = (trial >= {1'b0, dsr_reg});
        rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
        quo_next = {quo_reg[DIV_N_W-2:0], fits};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        else if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- design/pid_conditional_antiwindup.sv -----
// pid controller with conditional-integration anti-windup, bit-serial datapath
// datapath: six products on a serial multiplier and up to three quotients on a
// serial divider; the limit quotient is skipped when ki is tiny
// throughput: one item at a time; the next input is taken as soon as the
// result sits in the output register
// reset: gains, bias, integral and previous error clear to zero; ready at once
module pid_conditional_antiwindup
    import pca_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    pca_in_if.sink                in_chan,
    pca_out_if.source             out_chan
);

    localparam int SUM_W = 35;
    localparam logic [DIV_N_W-1:0] LIM_NUM  = DIV_N_W'(64'd255 << (2 * FRAC_BITS));
    localparam logic [31:0]        TINY_KI  = 32'((64'd1 << FRAC_BITS) / 64'd1000000);
    localparam logic [46:0]        LIM_TINY = 47'(64'd10000 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] TOP = SUM_W'(64'd255 << FRAC_BITS);

    // saturate a sign and magnitude to signed 32 bits
    function automatic logic signed [31:0] sat_mag(input logic neg,
                                                   input logic [PROD_W-1:0] mag);
        logic signed [31:0] r;
        if (!neg)
        begin
            r = (|mag[PROD_W-1:31]) ? 32'sh7FFF_FFFF : $signed({1'b0, mag[30:0]});
        end
        else
        begin
            r = ((|mag[PROD_W-1:32]) || (mag[31] && (|mag[30:0])))
                ? 32'sh8000_0000 : $signed(-mag[31:0]);
        end
        return r;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [47:0] abs48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    pca_state_t state_reg, state_next;
    logic       launched_reg;

    logic signed [31:0] kp_reg, ki_reg, kd_reg, bias_reg;
    logic signed [47:0] ei_reg;
    logic signed [31:0] prev_reg;

    logic signed [31:0] e_reg, der_reg, p_reg, d_reg, i_reg;
    logic        [15:0] m_reg;
    logic signed [49:0] inc_reg;
    logic        [46:0] lim_reg;
    logic signed [47:0] cand_reg;

    logic               out_valid_reg;
    logic        [15:0] drive_out_reg;
    logic signed [31:0] p_out_reg, i_out_reg, d_out_reg;

    logic                mul_start, mul_done;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_prod;
    logic                div_start, div_done;
    logic [DIV_N_W-1:0]  div_n;
    logic [DIV_D_W-1:0]  div_d;
    logic [DIV_N_W-1:0]  div_q;

    logic                in_fire;
    logic signed [32:0]  err_wide;
    logic signed [32:0]  de_wide;
    logic [32:0]         de_mag;
    logic [31:0]         aki;
    logic                ki_tiny;
    logic [PROD_W-1:0]   prod_q;
    logic signed [31:0]  mulq_res;
    logic signed [49:0]  cand_raw;
    logic signed [49:0]  lim_s;
    logic signed [SUM_W-1:0] unsat;
    logic signed [SUM_W-1:0] total;
    logic [SUM_W-1:0]    total_clamped;
    logic                keep_cand;
    logic                out_free;
    logic                step_done;

    pca_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .prod  (mul_prod),
        .done  (mul_done)
    );

    pca_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    // handshake
    assign in_chan.ready = (state_reg == ST_IDLE);
    assign in_fire       = in_chan.valid && in_chan.ready;
    assign out_free      = !out_valid_reg || out_chan.ready;

    // error and derivative numerator
    assign err_wide = {in_chan.target_value[31], in_chan.target_value}
                    - {in_chan.measured_value[31], in_chan.measured_value};
    assign de_wide  = {e_reg[31], e_reg} - {prev_reg[31], prev_reg};
    assign de_mag   = de_wide[32] ? 33'(-de_wide) : 33'(de_wide);

    assign aki     = abs32(ki_reg);
    assign ki_tiny = (aki <= TINY_KI);

    // product scaled back to Q and saturated, sign from the operands
    assign prod_q = mul_prod >> FRAC_BITS;

    // candidate integral, limit and the wide sums; the candidate i term is
    // taken straight from the finishing product
    assign cand_raw = {{2{ei_reg[47]}}, ei_reg} + inc_reg;
    assign lim_s    = $signed({3'b000, lim_reg});
    assign unsat    = SUM_W'(p_reg) + SUM_W'(mulq_res) + SUM_W'(d_reg) + SUM_W'(bias_reg);
    assign total    = SUM_W'(p_reg) + SUM_W'(i_reg) + SUM_W'(d_reg) + SUM_W'(bias_reg);
    assign keep_cand = !(((unsat > TOP) && (e_reg > 0)) || ((unsat < 0) && (e_reg < 0)));

    always_comb
    begin
        if (total < 0)
        begin
            total_clamped = '0;
        end
        else if (total > TOP)
        begin
            total_clamped = TOP;
        end
        else
        begin
            total_clamped = total;
        end
    end

    // operand selection and sign of the current product
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        div_n    = mul_prod[DIV_N_W-1:0];
        div_d    = {16'd0, m_reg};
        mulq_res = '0;
        unique case (state_reg)
            ST_DMUL:
            begin
                mul_a = 32'd1000;
                mul_b = 48'(de_mag);
            end
            ST_PMUL:
            begin
                mul_a    = abs32(kp_reg);
                mul_b    = {16'd0, abs32(e_reg)};
                mulq_res = sat_mag(kp_reg[31] ^ e_reg[31], prod_q);
            end
            ST_DKMUL:
            begin
                mul_a    = abs32(kd_reg);
                mul_b    = {16'd0, abs32(der_reg)};
                mulq_res = sat_mag(kd_reg[31] ^ der_reg[31], prod_q);
            end
            ST_IMUL:
            begin
                mul_a = {16'd0, m_reg};
                mul_b = {16'd0, abs32(e_reg)};
            end
            ST_IDIV:
            begin
                div_d = 32'd1000;
            end
            ST_LDIV:
            begin
                div_n = LIM_NUM;
                div_d = aki;
            end
            ST_KCMUL:
            begin
                mul_a    = aki;
                mul_b    = abs48(cand_reg);
                mulq_res = sat_mag(ki_reg[31] ^ cand_reg[47], prod_q);
            end
            ST_IFMUL:
            begin
                mul_a    = aki;
                mul_b    = abs48(ei_reg);
                mulq_res = sat_mag(ki_reg[31] ^ ei_reg[47], prod_q);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // unit launch and completion
    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        step_done = 1'b0;
        unique case (state_reg)
            ST_DMUL, ST_PMUL, ST_DKMUL, ST_IMUL, ST_KCMUL, ST_IFMUL:
            begin
                mul_start = !launched_reg;
                step_done = launched_reg && mul_done;
            end
            ST_DDIV, ST_IDIV:
            begin
                div_start = !launched_reg;
                step_done = launched_reg && div_done;
            end
            ST_LDIV:
            begin
                div_start = !launched_reg && !ki_tiny;
                step_done = ki_tiny || (launched_reg && div_done);
            end
            default:
            begin
                step_done = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_fire)   state_next = ST_DMUL;
            ST_DMUL:  if (step_done) state_next = ST_DDIV;
            ST_DDIV:  if (step_done) state_next = ST_PMUL;
            ST_PMUL:  if (step_done) state_next = ST_DKMUL;
            ST_DKMUL: if (step_done) state_next = ST_IMUL;
            ST_IMUL:  if (step_done) state_next = ST_IDIV;
            ST_IDIV:  if (step_done) state_next = ST_LDIV;
            ST_LDIV:  if (step_done) state_next = ST_CAND;
            ST_CAND:  state_next = ST_KCMUL;
            ST_KCMUL: if (step_done) state_next = ST_IFMUL;
            ST_IFMUL: if (step_done) state_next = ST_OUT;
            ST_OUT:   if (out_free)  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control, configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            kp_reg        <= '0;
            ki_reg        <= '0;
            kd_reg        <= '0;
            bias_reg      <= '0;
            ei_reg        <= '0;
            prev_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (mul_start || div_start)
            begin
                launched_reg <= 1'b1;
            end
            else if (step_done)
            begin
                launched_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_KP:   kp_reg   <= $signed(cfg_data);
                    REG_KI:   ki_reg   <= $signed(cfg_data);
                    REG_KD:   kd_reg   <= $signed(cfg_data);
                    REG_BIAS: bias_reg <= $signed(cfg_data);
                    default:  ;
                endcase
            end

            // conditional integration
            if ((state_reg == ST_KCMUL) && step_done && keep_cand)
            begin
                ei_reg <= cand_reg;
            end

            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
                prev_reg      <= e_reg;
            end
            else if (out_valid_reg && out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working registers of one item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (err_wide > 33'sh0_7FFF_FFFF)
            begin
                e_reg <= 32'sh7FFF_FFFF;
            end
            else if (err_wide < -33'sh0_8000_0000)
            begin
                e_reg <= 32'sh8000_0000;
            end
            else
            begin
                e_reg <= err_wide[31:0];
            end
            m_reg <= (in_chan.elapsed_ms == 16'd0) ? 16'd1 : in_chan.elapsed_ms;
        end

        if (step_done)
        begin
            unique case (state_reg)
                ST_DDIV:  der_reg <= sat_mag(de_wide[32], PROD_W'(div_q));
                ST_PMUL:  p_reg   <= mulq_res;
                ST_DKMUL: d_reg   <= mulq_res;
                ST_IDIV:  inc_reg <= e_reg[31] ? -$signed({1'b0, div_q[48:0]})
                                               : $signed({1'b0, div_q[48:0]});
                ST_LDIV:
                begin
                    if (ki_tiny)
                    begin
                        lim_reg <= LIM_TINY;
                    end
                    else
                    begin
                        lim_reg <= (|div_q[DIV_N_W-1:47]) ? {47{1'b1}} : div_q[46:0];
                    end
                end
                ST_IFMUL: i_reg   <= mulq_res;
                default:  ;
            endcase
        end

        // clamp candidate to the limit
        if (state_reg == ST_CAND)
        begin
            if (cand_raw > lim_s)
            begin
                cand_reg <= 48'(lim_s);
            end
            else if (cand_raw < -lim_s)
            begin
                cand_reg <= 48'(-lim_s);
            end
            else
            begin
                cand_reg <= cand_raw[47:0];
            end
        end

        // result beat
        if ((state_reg == ST_OUT) && out_free)
        begin
            drive_out_reg <= 16'(total_clamped >> (FRAC_BITS - 8));
            p_out_reg     <= p_reg;
            i_out_reg     <= i_reg;
            d_out_reg     <= d_reg;
        end
    end

    assign out_chan.valid       = out_valid_reg;
    assign out_chan.drive_value = drive_out_reg;
    assign out_chan.p_term      = p_out_reg;
    assign out_chan.i_term      = i_out_reg;
    assign out_chan.d_term      = d_out_reg;

endmodule

// ----- sim/tb_pid_conditional_antiwindup.sv -----
// self-checking testbench for the pid controller with conditional-integration anti-windup
`timescale 1ns / 100ps

module tb_pid_conditional_antiwindup;
    import pca_pkg::*;

    localparam int FRAC = 16;
    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD = 1500;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd6;

    typedef struct {
        logic        [15:0] drive;
        logic signed [31:0] p;
        logic signed [31:0] i;
        logic signed [31:0] d;
    } pid_result_t;

    // controller model with its own gains and loop state
    class pid_scoreboard;
        longint kp, ki, kd, bias;
        longint integ, prev_err;
        pid_result_t pending[$];
        int errors;
        int checked;

        function new();
            kp = 0; ki = 0; kd = 0; bias = 0;
            integ = 0; prev_err = 0;
            errors = 0; checked = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                REG_KP:   kp = v;
                REG_KI:   ki = v;
                REG_KD:   kd = v;
                REG_BIAS: bias = v;
                default: ;
            endcase
        endfunction

        function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // exact product, shifted toward zero, saturated to 32 bits
        function longint mul_q(longint a, longint b);
            logic [95:0] ua, ub, prod;
            longint mag;
            bit neg;
            neg = (a < 0) != (b < 0);
            ua = (a < 0) ? 96'(-a) : 96'(a);
            ub = (b < 0) ? 96'(-b) : 96'(b);
            prod = (ua * ub) >> FRAC;
            if (prod > 96'h1_0000_0000) mag = 64'sh1_0000_0000;
            else mag = longint'(prod);
            return sat32(neg ? -mag : mag);
        endfunction

        function void note_input(logic signed [31:0] tgt, logic signed [31:0] meas,
                                 logic [15:0] ms);
            longint m, e, der, p, d, cand, lim, aki, top, unsat, i_val, total;
            pid_result_t r;
            m = (ms == 0) ? 1 : longint'(ms);
            e = sat32(longint'(tgt) - longint'(meas));
            der = sat32(((e - prev_err) * 1000) / m);
            prev_err = e;
            p = mul_q(kp, e);
            d = mul_q(kd, der);
            cand = integ + (e * m) / 1000;
            aki = (ki < 0) ? -ki : ki;
            // tiny integral gain falls back to a fixed limit
            if (aki * 1000000 > (64'sd1 <<< FRAC)) lim = (64'sd255 <<< (2 * FRAC)) / aki;
            else lim = 64'sd10000 <<< FRAC;
            if (lim > (64'sd1 <<< 47) - 1) lim = (64'sd1 <<< 47) - 1;
            if (cand > lim) cand = lim;
            if (cand < -lim) cand = -lim;
            // keep the integral unless it pushes further into saturation
            top = 64'sd255 <<< FRAC;
            unsat = p + mul_q(ki, cand) + d + bias;
            if (!((unsat > top && e > 0) || (unsat < 0 && e < 0))) integ = cand;
            i_val = mul_q(ki, integ);
            total = p + i_val + d + bias;
            if (total < 0) total = 0;
            if (total > top) total = top;
            r.drive = 16'(total >>> (FRAC - 8));
            r.p = 32'(p);
            r.i = 32'(i_val);
            r.d = 32'(d);
            pending.push_back(r);
        endfunction

        function void check_result(logic [15:0] drive, logic signed [31:0] p,
                                   logic signed [31:0] i, logic signed [31:0] d);
            pid_result_t x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected beat drive=%h p=%h i=%h d=%h", $time,
                         drive, p, i, d);
                errors++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (drive !== x.drive) begin
                $display("%0t: drive expected %h actual %h", $time, x.drive, drive);
                errors++;
            end
            if (p !== x.p) begin
                $display("%0t: p_term expected %h actual %h", $time, x.p, p);
                errors++;
            end
            if (i !== x.i) begin
                $display("%0t: i_term expected %h actual %h", $time, x.i, i);
                errors++;
            end
            if (d !== x.d) begin
                $display("%0t: d_term expected %h actual %h", $time, x.d, d);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    pca_in_if in_chan ();
    pca_out_if out_chan ();

    pid_scoreboard sb;
    bit no_idle;
    bit hold_long;
    int idle_cycles;
    int phases_run;

    pid_conditional_antiwindup #(.FRAC_BITS(FRAC)) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver with random stalls and an occasional long hold-off
    initial
    begin
        int stall;
        out_chan.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (hold_long) begin
                stall = LONG_HOLD;
                hold_long = 1'b0;
            end
            if (stall > 0) begin
                out_chan.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_chan.ready <= 1'b1;
            do @(posedge clk); while (!out_chan.valid);
            sb.check_result(out_chan.drive_value, out_chan.p_term, out_chan.i_term,
                            out_chan.d_term);
        end
    end

    task automatic send_item(logic [31:0] tgt, logic [31:0] meas, logic [15:0] ms);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.target_value <= tgt;
        in_chan.measured_value <= meas;
        in_chan.elapsed_ms <= ms;
        do @(posedge clk); while (!in_chan.ready);
        sb.note_input(tgt, meas, ms);
    endtask

    // wait for every outstanding result, then let the block settle
    task automatic drain();
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
        repeat (20) @(posedge clk);
    endtask

    // one write cycle, then cfg_we is low again before the next write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] bias);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_BIAS, bias);
    endtask

    // mostly moderate gains, sometimes anything
    function automatic logic [31:0] rand_gain();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 32'h80000)) - 32'sh40000);
            default: return 32'($signed($urandom_range(0, 32'h2000)) - 32'sh1000);
        endcase
    endfunction

    function automatic logic [31:0] rand_value();
        if ($urandom_range(0, 4) == 0) return $urandom();
        return 32'($signed($urandom_range(0, 32'h1000000)) - 32'sh800000);
    endfunction

    function automatic logic [15:0] rand_ms();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'($urandom());
            default: return 16'($urandom_range(1, 100));
        endcase
    endfunction

    initial
    begin
        logic [31:0] base;
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_KP;
        cfg_data = '0;
        in_chan.valid = 1'b0;
        in_chan.target_value = '0;
        in_chan.measured_value = '0;
        in_chan.elapsed_ms = '0;
        no_idle = 1'b0;
        hold_long = 1'b0;
        idle_cycles = 0;
        phases_run = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, zero and full elapsed time
        set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0290, 32'h0000_0000);
        send_item(32'h0000_0000, 32'h0000_0000, 16'd0);
        send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send_item(32'h0010_0000, 32'h0000_0000, 16'd10);
        send_item(32'hFFF0_0000, 32'h0000_0000, 16'd0);
        send_item(32'h0000_0001, 32'hFFFF_FFFF, 16'd1000);
        drain();

        // tiny integral gain and an ignored register index
        set_gains(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0080_0000);
        write_reg(REG_SPARE, 32'hDEAD_BEEF);
        send_item(32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF);
        send_item(32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF);
        drain();
        write_reg(REG_KI, 32'h0000_0001);
        send_item(32'h0001_0000, 32'h0000_0000, 16'd5);
        drain();

        // large stored integral against a new, large ki
        set_gains(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_item(32'h0100_0000, 32'h0000_0000, 16'd100);
        drain();
        set_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_item(32'h8000_0000, 32'h0000_0000, 16'd0);
        send_item(32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF);
        drain();
        set_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_item(32'h0000_1000, 32'h0000_0000, 16'd3);
        send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'd1);
        drain();

        // random phases with new gains each time
        for (int ph = 0; ph < 10; ph++) begin
            set_gains(rand_gain(), rand_gain(), rand_gain(), rand_gain());
            phases_run++;
            no_idle = (ph % 4 == 1);
            if (ph == 3) hold_long = 1'b1;
            base = rand_value();
            for (int k = 0; k < 93; k++) begin
                // settling traces near the setpoint, with some wild samples
                if ($urandom_range(0, 3) != 0)
                    send_item(base, 32'(base + $signed($urandom_range(0, 32'h40000))
                              - 32'sh20000), rand_ms());
                else
                    send_item(rand_value(), rand_value(), rand_ms());
                if (k == 46 && ph % 3 == 0) drain();
            end
            drain();
        end

        repeat (600) @(posedge clk);
        $display("covered %0d results over %0d random gain sets plus directed edge cases",
                 sb.checked, phases_run);
        $display("including zero and full elapsed time, tiny ki and output back-pressure");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
